/* rtl/odq_pkg.sv */
// Shared constants, codes and types of the output-restricted deque.
package odq_pkg;

    localparam int DEPTH    = 16;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Per-cell control; at most one member is set in any cycle.
    typedef struct packed {
        logic load;         // take the incoming request word
        logic shift_rear;   // take the word of the neighbor nearer the front
        logic shift_front;  // take the word of the neighbor nearer the rear
    } cell_ctrl_t;

endpackage

/* rtl/odq_cell.sv */
// One storage cell of the deque chain.
module odq_cell
(
    input  logic                        clk,
    input  odq_pkg::cell_ctrl_t         ctrl,
    input  logic [odq_pkg::WORD_W-1:0]  load_word,
    input  logic [odq_pkg::WORD_W-1:0]  from_front,
    input  logic [odq_pkg::WORD_W-1:0]  from_rear,
    output logic [odq_pkg::WORD_W-1:0]  word
);

    logic [odq_pkg::WORD_W-1:0] word_reg;
    logic [odq_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        if (ctrl.load)
        begin
            word_next = load_word;
        end
        else if (ctrl.shift_rear)
        begin
            word_next = from_front;
        end
        else if (ctrl.shift_front)
        begin
            word_next = from_rear;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    // Payload storage needs no reset; the count decides which cells are live.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/output_restricted_deque_top.sv */
// Top level of the output-restricted deque: cell chain, occupancy count and result register.
//
// The block stores up to DEPTH signed 32-bit words in a row of cells, with cell 0 always
// holding the front word. Each request pushes a word at the front, pushes one at the rear,
// or pops the front word, and produces exactly one result carrying the popped word (zero
// unless a pop succeeded), a status (done, refused because full, or pop refused because
// empty) and the occupancy after the request. A mode of three changes nothing and reports
// done. A request is taken whenever the result register is empty or its result is being
// taken in the same cycle, so with no stall at the output one request is accepted every
// clock and its result appears on the next. A front push shifts every cell one place toward
// the rear, a pop shifts every cell one place toward the front, and a rear push writes only
// the cell addressed by the current count, so the update is one shift of the chain or one
// cell write, plus one count increment or decrement.
module output_restricted_deque_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [odq_pkg::MODE_W-1:0]          mode,
    input  logic signed [odq_pkg::WORD_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [odq_pkg::WORD_W-1:0]   popped,
    output logic [odq_pkg::STATUS_W-1:0]        status,
    output logic [odq_pkg::OCC_W-1:0]           occupancy
);

    logic [odq_pkg::CNT_W-1:0]      count_reg;
    logic [odq_pkg::CNT_W-1:0]      count_next;
    logic                           out_valid_reg;
    logic [odq_pkg::WORD_W-1:0]     popped_reg;
    logic [odq_pkg::WORD_W-1:0]     popped_next;
    logic [odq_pkg::STATUS_W-1:0]   status_reg;
    logic [odq_pkg::STATUS_W-1:0]   status_next;
    logic [odq_pkg::OCC_W-1:0]      occ_reg;

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic                           do_push_front;
    logic                           do_push_rear;
    logic                           do_pop;

    logic [odq_pkg::WORD_W-1:0]     words [odq_pkg::DEPTH];
    odq_pkg::cell_ctrl_t            ctrl  [odq_pkg::DEPTH];

    // A new request is held off only while an untaken result sits in the output register.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full  = (count_reg == odq_pkg::CNT_W'(odq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    assign do_push_front = accept && (mode == odq_pkg::MODE_PUSH_FRONT) && !full;
    assign do_push_rear  = accept && (mode == odq_pkg::MODE_PUSH_REAR)  && !full;
    assign do_pop        = accept && (mode == odq_pkg::MODE_POP_FRONT)  && !empty;

    // The chain: cell 0 is the front. The front cell takes the request word on a front
    // push, and the rear cell simply reloads itself on a pop, since that slot becomes dead.
    for (genvar i = 0; i < odq_pkg::DEPTH; i++)
    begin : g_cell
        logic [odq_pkg::WORD_W-1:0] front_src;
        logic [odq_pkg::WORD_W-1:0] rear_src;

        if (i == 0)
        begin : g_first
            assign front_src = value;
        end
        else
        begin : g_mid_front
            assign front_src = words[i-1];
        end

        if (i == odq_pkg::DEPTH - 1)
        begin : g_last
            assign rear_src = words[i];
        end
        else
        begin : g_mid_rear
            assign rear_src = words[i+1];
        end

        assign ctrl[i].load        = do_push_rear && (count_reg == odq_pkg::CNT_W'(i));
        assign ctrl[i].shift_rear  = do_push_front;
        assign ctrl[i].shift_front = do_pop;

        odq_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .load_word  (value),
            .from_front (front_src),
            .from_rear  (rear_src),
            .word       (words[i])
        );
    end

    // Count update and the result of the current request.
    always_comb
    begin
        count_next  = count_reg;
        popped_next = '0;
        status_next = odq_pkg::ST_DONE;
        case (mode)
            odq_pkg::MODE_PUSH_FRONT,
            odq_pkg::MODE_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = odq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + odq_pkg::CNT_W'(1);
                end
            end
            odq_pkg::MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = odq_pkg::ST_EMPTY;
                end
                else
                begin
                    popped_next = words[0];
                    count_next  = count_reg - odq_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a request is accepted, so a stalled result holds.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            occ_reg    <= odq_pkg::OCC_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign popped    = popped_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

`ifndef NO_ASSERTIONS
    // Every accepted request leaves a result behind on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    // A refused push is reported only when the store holds DEPTH words.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == odq_pkg::ST_FULL) |->
            (occupancy == odq_pkg::OCC_W'(odq_pkg::DEPTH)))
        else $error("full status with store not full");

    // A refused pop is reported only on an empty store and carries no word.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == odq_pkg::ST_EMPTY) |-> (occupancy == '0 && popped == '0))
        else $error("empty status inconsistent");

    // A successful pop lowers the count by exactly one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (count_reg == $past(count_reg) - odq_pkg::CNT_W'(1)))
        else $error("pop did not decrement count");
`endif

endmodule

/* tb/sv/output_restricted_deque_top_tb.sv */
// Self-checking testbench for the output-restricted deque with a queue-based result predictor.
module output_restricted_deque_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // A mode of three is a no-operation request; the package has no name for it.
    localparam logic [odq_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

    localparam logic signed [odq_pkg::WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
    localparam logic signed [odq_pkg::WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [odq_pkg::WORD_W-1:0] WORD_ZERO = 32'sh0000_0000;
    localparam logic signed [odq_pkg::WORD_W-1:0] WORD_ONES = 32'shffff_ffff;

    // One expected or observed result of a request.
    typedef struct {
        logic signed [odq_pkg::WORD_W-1:0] popped;
        logic [odq_pkg::STATUS_W-1:0]      status;
        logic [odq_pkg::OCC_W-1:0]         occupancy;
    } deque_result_t;

    logic                              clk;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [odq_pkg::MODE_W-1:0]        mode      = MODE_NOP;
    logic signed [odq_pkg::WORD_W-1:0] value     = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [odq_pkg::WORD_W-1:0] popped;
    logic [odq_pkg::STATUS_W-1:0]      status;
    logic [odq_pkg::OCC_W-1:0]         occupancy;

    // The predictor keeps the stored words as a plain queue: index 0 is the front word.
    logic signed [odq_pkg::WORD_W-1:0] stored_words[$];
    deque_result_t                     pending_results[$];
    int                                failures = 0;

    // When set, both the request side and the result side idle at random.
    bit                                idle_on  = 1'b1;

    output_restricted_deque_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .popped    (popped),
        .status    (status),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run is bounded by a fixed time well above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Applies one accepted request to the predictor and queues the result it must produce.
    // Full and empty are judged from the number of stored words, and a no-operation
    // request leaves everything as it is and reports done.
    task automatic predict_deque_result(input logic [odq_pkg::MODE_W-1:0] req_mode,
                                        input logic signed [odq_pkg::WORD_W-1:0] req_value);
        deque_result_t res;
        res.popped = '0;
        res.status = odq_pkg::ST_DONE;
        case (req_mode)
            odq_pkg::MODE_PUSH_FRONT, odq_pkg::MODE_PUSH_REAR:
            begin
                if (stored_words.size() >= odq_pkg::DEPTH)
                    res.status = odq_pkg::ST_FULL;
                else if (req_mode == odq_pkg::MODE_PUSH_FRONT)
                    stored_words.push_front(req_value);
                else
                    stored_words.push_back(req_value);
            end
            odq_pkg::MODE_POP_FRONT:
            begin
                if (stored_words.size() == 0)
                    res.status = odq_pkg::ST_EMPTY;
                else
                    res.popped = stored_words.pop_front();
            end
            default:
            begin
            end
        endcase
        res.occupancy = odq_pkg::OCC_W'(stored_words.size());
        pending_results.push_back(res);
    endtask

    // Sends one request. It is called just after a rising edge, may first idle for a
    // random number of cycles, then holds the request until the edge at which in_stall
    // is low. Values are sampled at the edge, before any update made at that edge.
    task automatic send_request(input logic [odq_pkg::MODE_W-1:0] req_mode,
                                input logic signed [odq_pkg::WORD_W-1:0] req_value);
        if (idle_on)
        begin
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        mode     <= req_mode;
        value    <= req_value;
        do
            @(posedge clk);
        while (in_stall);
        predict_deque_result(req_mode, req_value);
    endtask

    // Random word, with the extreme values turning up often.
    function automatic logic signed [odq_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(11))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_ZERO;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Random mode: a few no-operation requests, pushes with the given weight in percent
    // split evenly between front and rear, and pops for the rest.
    function automatic logic [odq_pkg::MODE_W-1:0] random_mode(input int push_weight);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return MODE_NOP;
        else if (roll < 5 + push_weight)
            return $urandom_range(1) ? odq_pkg::MODE_PUSH_REAR : odq_pkg::MODE_PUSH_FRONT;
        else
            return odq_pkg::MODE_POP_FRONT;
    endfunction

    // Stops sending and waits until every expected result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The result side stalls at random while idling is on.
    always @(posedge clk)
        out_stall <= idle_on && ($urandom_range(99) < 37);

    // Every taken result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: popped %0d status %0d occupancy %0d",
                       popped, status, occupancy);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (popped !== want.popped)
                begin
                    $error("popped: expected %0d, got %0d", want.popped, popped);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    failures++;
                end
            end
        end
    end

    // An empty store refuses a pop, and a no-operation request reports done.
    task automatic test_empty_store();
        send_request(odq_pkg::MODE_POP_FRONT, WORD_MAX);
        send_request(MODE_NOP, WORD_MIN);
        send_request(odq_pkg::MODE_POP_FRONT, WORD_ONES);
    endtask

    // Words pushed at both ends with extreme values come out of the front in deque
    // order, and popping past the last word is refused again.
    task automatic test_front_and_rear_order();
        send_request(odq_pkg::MODE_PUSH_FRONT, WORD_MAX);
        send_request(odq_pkg::MODE_PUSH_REAR, WORD_MIN);
        send_request(odq_pkg::MODE_PUSH_FRONT, WORD_ONES);
        send_request(odq_pkg::MODE_PUSH_REAR, WORD_ZERO);
        send_request(MODE_NOP, WORD_MAX);
        repeat (4)
            send_request(odq_pkg::MODE_POP_FRONT, random_word());
        send_request(odq_pkg::MODE_POP_FRONT, WORD_ZERO);
    endtask

    // Filling the store completely makes both kinds of push be refused with a full
    // status, while a pop still works and frees one place.
    task automatic test_full_store();
        repeat (odq_pkg::DEPTH)
            send_request($urandom_range(1) ? odq_pkg::MODE_PUSH_REAR : odq_pkg::MODE_PUSH_FRONT,
                         random_word());
        send_request(odq_pkg::MODE_PUSH_FRONT, WORD_MIN);
        send_request(odq_pkg::MODE_PUSH_REAR, WORD_MAX);
        send_request(MODE_NOP, WORD_ZERO);
        send_request(odq_pkg::MODE_POP_FRONT, WORD_ZERO);
        send_request(odq_pkg::MODE_PUSH_REAR, WORD_ONES);
    endtask

    // Long random traffic. The push weight changes every few dozen requests so that
    // the store swings between empty and full many times.
    task automatic test_random_traffic(input int count);
        int push_weight;
        push_weight = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 48 == 0)
            begin
                case ($urandom_range(2))
                    0:       push_weight = 80;
                    1:       push_weight = 15;
                    default: push_weight = 47;
                endcase
            end
            send_request(random_mode(push_weight), random_word());
        end
    endtask

    // The sender pauses in the middle of traffic until every result has come back,
    // then carries on from the same store contents.
    task automatic test_drain_pause();
        test_random_traffic(60);
        wait_for_results();
        test_random_traffic(60);
    endtask

    // A long stretch with no idling on either side, so requests and results move on
    // every clock.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(300);
        idle_on = 1'b1;
    endtask

    initial
    begin
        int guard;

        // Reset is held low from the start and released once.
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_front_and_rear_order();
        test_full_store();
        test_drain_pause();
        test_random_traffic(800);
        test_back_to_back();
        test_random_traffic(800);

        // Let the remaining results drain, with a bound, then let the block sit idle.
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            failures++;
        end
        repeat (8)
            @(posedge clk);

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/odq_pkg.sv
rtl/odq_cell.sv
rtl/output_restricted_deque_top.sv
tb/sv/output_restricted_deque_top_tb.sv
